### design/ppu_pkg.sv
package ppu_pkg;

   typedef enum logic [1:0] {
      FMT_RGB888   = 2'd0,
      FMT_ARGB8888 = 2'd1,
      FMT_RGB444   = 2'd2,
      FMT_ARGB4444 = 2'd3
   } pixel_format_type;

   localparam int unsigned ACC_BITS  = 24;
   localparam int unsigned HELD_BITS = 5;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_image;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       last_pixel;
   } rsp_type;

   // Handshake between the pixel core and the result register.
   typedef struct packed {
      logic result_valid;
      logic out_free;
   } core_ctl_type;

   // A 4-bit channel times 17 is the nibble repeated.
   function automatic logic [7:0] widen4(input logic [3:0] c);
      widen4 = {c, c};
   endfunction

endpackage

### design/ppu_in_reg.sv
module ppu_in_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppu_pkg::req_type req_data,
   input  logic             consume,
   output logic             item_valid,
   output ppu_pkg::req_type item_data
);
   import ppu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   req_type data_ff;

   assign req_ready  = !valid_ff || consume;
   assign valid_in   = req_valid || (valid_ff && !consume);
   assign item_valid = valid_ff;
   assign item_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         data_ff <= req_data;
      end
   end

endmodule

### design/ppu_core.sv
module ppu_core (
   input  logic                      clock,
   input  logic                      reset,
   input  ppu_pkg::pixel_format_type pixel_format,
   input  logic                      item_valid,
   input  ppu_pkg::req_type          item_data,
   output logic                      consume,
   output ppu_pkg::core_ctl_type     ctl,
   input  logic                      out_free,
   output ppu_pkg::rsp_type          result
);
   import ppu_pkg::*;

   logic [ACC_BITS-1:0]  acc_ff;
   logic [ACC_BITS-1:0]  acc_in;
   logic [HELD_BITS-1:0] held_ff;
   logic [HELD_BITS-1:0] held_in;
   logic [HELD_BITS-1:0] held;
   logic [31:0]          v;
   logic [5:0]           total;
   logic [5:0]           size;
   logic                 complete;

   // A word format can leave more than 24 bits counted after a format change;
   // only 24 of them are actually kept.
   assign held  = (held_ff > HELD_BITS'(ACC_BITS)) ? HELD_BITS'(ACC_BITS) : held_ff;
   assign v     = {8'd0, acc_ff} | ({24'd0, item_data.data_byte} << held);
   assign total = {1'b0, held} + 6'd8;

   always_comb begin
      unique case (pixel_format)
         FMT_RGB444:   size = 6'd12;
         FMT_ARGB4444: size = 6'd16;
         default:      size = 6'd32;
      endcase
   end

   assign complete = (total >= size);
   assign consume  = item_valid && (!complete || out_free);
   assign ctl.result_valid = item_valid && complete && out_free;
   assign ctl.out_free     = out_free;

   always_comb begin
      acc_in  = acc_ff;
      held_in = held_ff;
      if (item_data.end_of_image) begin
         acc_in  = '0;
         held_in = '0;
      end else if (!complete) begin
         acc_in  = v[ACC_BITS-1:0];
         held_in = total[HELD_BITS-1:0];
      end else begin
         unique case (pixel_format)
            FMT_RGB444: begin
               acc_in  = {4'd0, v[31:12]};
               held_in = HELD_BITS'(total - 6'd12);
            end
            FMT_ARGB4444: begin
               acc_in  = {8'd0, v[31:16]};
               held_in = HELD_BITS'(total - 6'd16);
            end
            default: begin
               acc_in  = '0;
               held_in = '0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         held_ff <= '0;
      end else if (consume) begin
         acc_ff  <= acc_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      result.last_pixel = item_data.end_of_image;
      unique case (pixel_format)
         FMT_RGB888: begin
            result.red   = v[23:16];
            result.green = v[15:8];
            result.blue  = v[7:0];
            result.alpha = 8'hFF;
         end
         FMT_ARGB8888: begin
            result.red   = v[23:16];
            result.green = v[15:8];
            result.blue  = v[7:0];
            result.alpha = v[31:24];
         end
         FMT_RGB444: begin
            result.red   = widen4(v[11:8]);
            result.green = widen4(v[7:4]);
            result.blue  = widen4(v[3:0]);
            result.alpha = 8'hFF;
         end
         default: begin
            result.red   = widen4(v[11:8]);
            result.green = widen4(v[7:4]);
            result.blue  = widen4(v[3:0]);
            result.alpha = widen4(v[15:12]);
         end
      endcase
   end

endmodule

### design/ppu_out_reg.sv
module ppu_out_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  ppu_pkg::core_ctl_type ctl,
   input  ppu_pkg::rsp_type      result,
   output logic                  out_free,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ppu_pkg::rsp_type      rsp_data
);
   import ppu_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   rsp_type data_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign valid_in  = ctl.result_valid || (valid_ff && !rsp_ready);
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.result_valid && ctl.out_free) begin
         data_ff <= result;
      end
   end

endmodule

### design/packed_pixel_unpacker_top.sv
// Packed pixel unpacker: takes image bytes on the req_ channel and returns
// RGBA8888 pixels on the rsp_ channel, one each time a packed pixel of the
// selected format is complete (4 bytes for the 32-bit word formats, 2 bytes
// for ARGB4444, 1.5 bytes on average for packed RGB444).
// csr_write_enable writes the 2-bit pixel format; write it only while no
// transaction is in flight. A byte flagged end_of_image closes the image:
// its pixel, if it completes one, carries last_pixel, and any partial pixel
// is dropped so the next image starts aligned.
// A byte is held in the input register, where the accumulator and the
// channel widening are applied, and its pixel is then held in the result
// register. One byte is taken every cycle while req_ready is high; the
// accumulator update is the only loop.
// Reset clears the valid flags of both registers, the accumulator and the
// held bits, and selects RGB888. When the receiver stalls, the pixel waits
// in the result register while bytes that complete no pixel keep flowing; a
// byte that completes a pixel waits in the input register and req_ready drops until the result is taken.
module packed_pixel_unpacker_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ppu_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ppu_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [1:0]       csr_write_data
);
   import ppu_pkg::*;

   pixel_format_type pixel_format_ff;
   logic             item_valid;
   req_type          item_data;
   logic             consume;
   logic             out_free;
   core_ctl_type     ctl;
   rsp_type          result;

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_format_ff <= FMT_RGB888;
      end else if (csr_write_enable) begin
         pixel_format_ff <= pixel_format_type'(csr_write_data);
      end
   end

   ppu_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .consume    (consume),
      .item_valid (item_valid),
      .item_data  (item_data)
   );

   ppu_core u_core (
      .clock        (clock),
      .reset        (reset),
      .pixel_format (pixel_format_ff),
      .item_valid   (item_valid),
      .item_data    (item_data),
      .consume      (consume),
      .ctl          (ctl),
      .out_free     (out_free),
      .result       (result)
   );

   ppu_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .result    (result),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
